@@ hw/rtl/delimiter_sniffer_macros.svh @@
// assertion macros for the delimiter sniffer
// expects signals named clock and reset in the including scope
`ifndef DELIMITER_SNIFFER_MACROS_SVH
`define DELIMITER_SNIFFER_MACROS_SVH

// same-cycle implication, held off during reset
`define DS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define DS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ds_pkg.sv @@
// shared types, character codes and class functions for the delimiter sniffer
// no dependencies
package ds_pkg;

   localparam int BYTE_W     = 8;
   localparam int CHAR_W     = 7;
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   // header terminators
   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_NL     = 8'd10;
   // quote candidates
   localparam logic [BYTE_W-1:0] CHAR_DQUOTE = 8'd34;
   localparam logic [BYTE_W-1:0] CHAR_APOS   = 8'd39;
   localparam logic [BYTE_W-1:0] CHAR_BTICK  = 8'd96;
   // separator candidates
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_PIPE   = 8'd124;
   localparam logic [BYTE_W-1:0] PUNCT_A_LO  = 8'd33;
   localparam logic [BYTE_W-1:0] PUNCT_A_HI  = 8'd47;
   localparam logic [BYTE_W-1:0] PUNCT_B_LO  = 8'd58;
   localparam logic [BYTE_W-1:0] PUNCT_B_HI  = 8'd64;
   localparam logic [BYTE_W-1:0] PUNCT_C_LO  = 8'd91;
   localparam logic [BYTE_W-1:0] PUNCT_C_HI  = 8'd94;

   // register index, taken from the word address
   typedef enum logic {
      CSR_SNIFF_ENABLE  = 1'b0,
      CSR_INITIAL_QUOTE = 1'b1
   } csr_reg_type;

   function automatic logic is_quote_cand(input logic [BYTE_W-1:0] c);
      return (c == CHAR_DQUOTE) || (c == CHAR_APOS) || (c == CHAR_BTICK);
   endfunction

   function automatic logic is_sep_cand(input logic [BYTE_W-1:0] c);
      logic hit;
      hit = (c == CHAR_TAB) || (c == CHAR_PIPE) ||
            ((c >= PUNCT_A_LO) && (c <= PUNCT_A_HI)) ||
            ((c >= PUNCT_B_LO) && (c <= PUNCT_B_HI)) ||
            ((c >= PUNCT_C_LO) && (c <= PUNCT_C_HI));
      return hit && !is_quote_cand(c);
   endfunction

endpackage

@@ hw/rtl/ds_req_if.sv @@
// request channel of the delimiter sniffer: valid/ready plus one text byte
// depends on ds_pkg
interface ds_req_if
   import ds_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              start_of_text;

   modport source (output valid, output text_byte, output start_of_text, input ready);
   modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

@@ hw/rtl/ds_rsp_if.sv @@
// result channel of the delimiter sniffer: valid/ready plus current choices
// depends on ds_pkg
interface ds_rsp_if
   import ds_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] separator_choice;
   logic [CHAR_W-1:0] quote_choice;
   logic              header_done;

   modport source (output valid, output separator_choice, output quote_choice,
                   output header_done, input ready);
   modport sink   (input valid, input separator_choice, input quote_choice,
                   input header_done, output ready);
endinterface

@@ hw/rtl/delimiter_sniffer.sv @@
// delimiter sniffer top level: histogram memory, best-choice tracking, apb registers
// depends on ds_pkg, ds_req_if, ds_rsp_if and delimiter_sniffer_macros.svh
//
//   channel    direction  handshake            payload
//   req_chan   in         valid/ready          text_byte, start_of_text
//   rsp_chan   out        valid/ready          separator_choice, quote_choice, header_done
//   csr_*      in         apb write, pready=1  sniff_enable, initial_quote
//
// one request per cycle sustained unless rsp_chan stalls; the count memory is read at
// the accept edge and written as the request leaves into the output register
// a same-entry write by the preceding request is forwarded past the memory read
// reset clears the valid bits of the histogram at once, so no clearing pass runs;
// a start of text clears them the same way in the cycle that request is processed
// a stalled response holds the processing stage, which backs up into req_chan.ready
`include "delimiter_sniffer_macros.svh"

module delimiter_sniffer
   import ds_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int ALPHABET_SIZE = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   ds_req_if.sink                req_chan,
   ds_rsp_if.source              rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [APB_ADDR_W-1:0] csr_paddr,
   input  logic [APB_DATA_W-1:0] csr_pwdata,
   output logic [APB_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(ALPHABET_SIZE);

   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   // configuration registers
   logic              enable_ff;
   logic [CHAR_W-1:0] iquote_ff;
   logic              csr_write;

   // histogram memory, entries qualified by valid bits
   count_type         count_mem [ALPHABET_SIZE];
   count_type         rdata_ff;
   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;

   // processing stage
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_sot_ff;
   logic [AW-1:0]     s1_addr;
   logic              req_accept;
   logic              advance;

   // last committed write, for forwarding
   logic              wr_en_ff;
   logic [AW-1:0]     wr_addr_ff;
   count_type         wr_data_ff;
   logic              fwd_hit;

   // running choices and mirrored counts of the chosen characters
   logic [CHAR_W-1:0] best_sep_ff, best_sep_in;
   logic [CHAR_W-1:0] best_quote_ff, best_quote_in;
   count_type         sep_cnt_ff, sep_cnt_in;
   count_type         quote_cnt_ff, quote_cnt_in;
   logic              finished_ff, finished_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_sep_ff;
   logic [CHAR_W-1:0] out_quote_ff;
   logic              out_done_ff;

   // per-request working values
   count_type         cnt_old;
   count_type         cnt_new;
   logic              do_count;
   logic              is_quote;
   logic              is_sep;
   logic              is_term;
   logic [CHAR_W-1:0] s1_char;

   // ---------------------------------------------------------------- apb registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         iquote_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_paddr[2])) 
            CSR_SNIFF_ENABLE:  enable_ff <= csr_pwdata[0];
            CSR_INITIAL_QUOTE: iquote_ff <= csr_pwdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg_type'(csr_paddr[2]))
         CSR_SNIFF_ENABLE:  csr_prdata[0] = enable_ff;
         CSR_INITIAL_QUOTE: csr_prdata[CHAR_W-1:0] = iquote_ff;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   // the processing stage moves on whenever the output register is free or drains
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.separator_choice = out_sep_ff;
   assign rsp_chan.quote_choice     = out_quote_ff;
   assign rsp_chan.header_done      = out_done_ff;

   // ---------------------------------------------------------------- count memory
   // read at the accept edge, written when the request leaves the processing stage;
   // bytes above 127 never write, so only the low seven bits address the memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rdata_ff <= count_mem[AW'(req_chan.text_byte[CHAR_W-1:0])];
      end
      if (advance && do_count) begin
         count_mem[s1_addr] <= cnt_new;
      end
   end

   // ---------------------------------------------------------------- processing stage
   assign s1_char  = s1_byte_ff[CHAR_W-1:0];
   assign s1_addr  = AW'(s1_char);
   assign is_quote = is_quote_cand(s1_byte_ff);
   assign is_sep   = is_sep_cand(s1_byte_ff);
   assign is_term  = (s1_byte_ff == CHAR_NL) || (s1_byte_ff == CHAR_NUL);

   // the preceding request may have written this entry at the edge we read it
   assign fwd_hit = wr_en_ff && (wr_addr_ff == s1_addr);

   always_comb begin
      logic              fin_base;
      logic [CHAR_W-1:0] bs_base;
      logic [CHAR_W-1:0] bq_base;
      count_type         sc_base;
      count_type         qc_base;

      // a start of text empties the histogram and restores the initial choices
      if (s1_sot_ff) begin
         fin_base = 1'b0;
         bs_base  = '0;
         bq_base  = iquote_ff;
         sc_base  = '0;
         qc_base  = '0;
         cnt_old  = '0;
      end else begin
         fin_base = finished_ff;
         bs_base  = best_sep_ff;
         bq_base  = best_quote_ff;
         sc_base  = sep_cnt_ff;
         qc_base  = quote_cnt_ff;
         if (fwd_hit) begin
            cnt_old = wr_data_ff;
         end else if (valid_ff[s1_addr]) begin
            cnt_old = rdata_ff;
         end else begin
            cnt_old = '0;
         end
      end

      // saturating increment
      cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

      do_count = !fin_base && !is_term && enable_ff && !s1_byte_ff[BYTE_W-1] &&
                 (is_quote || is_sep);

      finished_in  = fin_base || is_term;
      best_sep_in  = bs_base;
      best_quote_in = bq_base;
      sep_cnt_in   = sc_base;
      quote_cnt_in = qc_base;

      if (do_count) begin
         // strict compare keeps the earlier choice on a tie; otherwise keep the
         // mirrored count live when the counted byte is the chosen character
         if (is_quote && (cnt_new > qc_base)) begin
            best_quote_in = s1_char;
            quote_cnt_in  = cnt_new;
         end else if (s1_char == bq_base) begin
            quote_cnt_in  = cnt_new;
         end
         if (is_sep && (cnt_new > sc_base)) begin
            best_sep_in = s1_char;
            sep_cnt_in  = cnt_new;
         end else if (s1_char == bs_base) begin
            sep_cnt_in  = cnt_new;
         end
      end

      valid_in = s1_sot_ff ? '0 : valid_ff;
      if (do_count) begin
         valid_in[s1_addr] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         wr_en_ff      <= 1'b0;
         valid_ff      <= '0;
         finished_ff   <= 1'b0;
         best_sep_ff   <= '0;
         best_quote_ff <= '0;
         sep_cnt_ff    <= '0;
         quote_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            wr_en_ff      <= do_count;
            valid_ff      <= valid_in;
            finished_ff   <= finished_in;
            best_sep_ff   <= best_sep_in;
            best_quote_ff <= best_quote_in;
            sep_cnt_ff    <= sep_cnt_in;
            quote_cnt_ff  <= quote_cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_chan.text_byte;
         s1_sot_ff  <= req_chan.start_of_text;
      end
      if (advance) begin
         wr_addr_ff   <= s1_addr;
         wr_data_ff   <= cnt_new;
         out_sep_ff   <= best_sep_in;
         out_quote_ff <= best_quote_in;
         out_done_ff  <= finished_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   `DS_ASSERT_NOW(a_fwd_entry_valid, wr_en_ff, valid_ff[wr_addr_ff], "forwarded entry not valid")
   `DS_ASSERT_NOW(a_no_count_after_end, advance && finished_ff && !s1_sot_ff, !do_count, "count after header end")
   `DS_ASSERT_NOW(a_sep_is_cand, out_valid_ff, (out_sep_ff == '0) || is_sep_cand({1'b0, out_sep_ff}), "separator not a candidate")
   `DS_ASSERT_NEXT(a_accept_fills_stage, req_accept, s1_valid_ff, "accepted request lost")

endmodule
